[rtl/frs_pkg.sv]
// Shared types and constants for the frame-rate statistics block.
`timescale 1ns / 1ps

package frs_pkg;

  // Field widths
  localparam int unsigned IDEAL_W   = 20;
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned FPS_W     = 28;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SUM_W     = 56;
  localparam int unsigned JIT_W     = 60;

  // Shared divider geometry
  localparam int unsigned DIV_NUM_W  = 64;
  localparam int unsigned DIV_DEN_W  = 56;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_NUM_W + 1);

  // Steps for a 28-bit rate dividend and for a 60-bit wide dividend
  localparam logic [DIV_STEP_W-1:0] RATE_STEPS = DIV_STEP_W'(FPS_W);
  localparam logic [DIV_STEP_W-1:0] WIDE_STEPS = DIV_STEP_W'(JIT_W);

  // One second in Q.8 microsecond units: 1e6 * 256
  localparam logic [FPS_W-1:0] ONE_SEC_Q8 = FPS_W'(256000000);

  // Reset value of the ideal frame period
  localparam logic [IDEAL_W-1:0] IDEAL_RESET = IDEAL_W'(16666);

  // Input mode codes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [ELAPSED_W-1:0] elapsed_us;
  } frame_t;

  typedef struct packed {
    logic [FPS_W-1:0] average_fps;
    logic [FPS_W-1:0] minimum_fps;
    logic [FPS_W-1:0] maximum_fps;
    logic [FPS_W-1:0] jitter_fps;
  } stats_t;

  // Divider command: dividend is left-aligned, steps gives its bit count
  typedef struct packed {
    logic                  start;
    logic [DIV_NUM_W-1:0]  dividend;
    logic [DIV_DEN_W-1:0]  divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [FPS_W-1:0] quotient;
    logic             overflow;
  } div_res_t;

endpackage

[rtl/frs_stream_if.sv]
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps

interface frs_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/frs_divider.sv]
// Shared restoring divider, one quotient bit per cycle, saturation flag.
`timescale 1ns / 1ps

module frs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frs_pkg::div_cmd_t  cmd_i,
  output frs_pkg::div_res_t  res_o
);
  import frs_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic                  ovf_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0]  num_q;
  logic [DIV_DEN_W-1:0]  den_q;
  logic [DIV_DEN_W-1:0]  rem_q;
  logic [FPS_W-1:0]      quo_q;

  logic [DIV_DEN_W:0]    rem_sh;
  logic [DIV_DEN_W:0]    rem_diff;
  logic                  q_bit;
  logic [DIV_DEN_W-1:0]  rem_nxt;

  // Shift in the next dividend bit, trial subtract
  assign rem_sh   = {rem_q, num_q[DIV_NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign q_bit    = (rem_sh >= {1'b0, den_q});
  assign rem_nxt  = q_bit ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        ovf_q  <= 1'b0;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        // Any bit pushed out of the quotient window means saturation
        ovf_q <= ovf_q | quo_q[FPS_W-1];
        cnt_q <= cnt_q - DIV_STEP_W'(1);
        if (cnt_q == DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q <= cmd_i.dividend;
      den_q <= cmd_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
      rem_q <= rem_nxt;
      quo_q <= {quo_q[FPS_W-2:0], q_bit};
    end
  end

  assign res_o.busy     = busy_q;
  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;
  assign res_o.overflow = ovf_q;

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

  a_busy_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(cmd_i.start))
    else $error("divider busy without start");

endmodule

[rtl/frame_rate_statistics_core.sv]
// Top level of the frame-rate statistics block: sequencer and statistics state.
`timescale 1ns / 1ps

// Frame-rate statistics. Each transaction on frame_i either records one frame
// (mode 0, elapsed_us microseconds since the previous frame, 0 counts as 1)
// or clears the statistics (mode 1). Every transaction returns one stats_o
// transaction with average, minimum, maximum and jitter rates in unsigned
// Q20.8 frames per second, each saturating at 2^28-1 and reading 0 when its
// divisor is empty. The first frame after reset uses the ideal period
// (cfg register, written through cfg_we_i/cfg_data_i; the user writes it only
// while idle, the block itself does not enforce this) instead of elapsed_us.
// Frame times saturate at 2^TIME_BITS-1. All divisions run on one shared
// restoring divider that yields one quotient bit per cycle: a recorded frame
// needs six divisions (four with a 28-bit rate dividend, two with a 60-bit
// wide dividend), each launched in ST_LAUNCH and collected in ST_WAIT; a
// clear skips its divisions. frame_i is ready only while the sequencer is
// idle, which it reenters on loading the result, so no new frame is accepted
// until then. The result sits in an output register until taken; a new
// result waits for that register.
module frame_rate_statistics_core #(
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [frs_pkg::IDEAL_W-1:0]  cfg_data_i,
  frs_stream_if.sink                   frame_i,
  frs_stream_if.source                 stats_o
);
  import frs_pkg::*;

  localparam logic [32:0] TIME_MAX_W = (33'd1 << TIME_BITS) - 33'd1;
  localparam int unsigned AVG_PROD_W = FPS_W + COUNT_W;
  localparam logic [DIV_NUM_W-1:0] RATE_DIVIDEND =
    {ONE_SEC_Q8, {(DIV_NUM_W - FPS_W){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LAUNCH,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_FI,
    OP_FT,
    OP_AVG,
    OP_MIN,
    OP_MAX,
    OP_JIT
  } op_e;

  state_e state_q;
  op_e    op_q;

  // Configuration and per-transaction registers
  logic [IDEAL_W-1:0]   ideal_q;
  logic                 mode_q;
  logic [TIME_BITS-1:0] cur_t_q;
  logic [TIME_BITS-1:0] ideal_t_q;

  // Statistics
  logic                 started_q;
  logic [COUNT_W-1:0]   frame_count_q;
  logic [SUM_W-1:0]     time_sum_q;
  logic [TIME_BITS-1:0] shortest_q;
  logic [TIME_BITS-1:0] longest_q;
  logic [JIT_W-1:0]     jitter_sum_q;

  // Division results
  logic [FPS_W-1:0]     fi_q;
  logic [FPS_W-1:0]     avg_q;
  logic [FPS_W-1:0]     min_q;
  logic [FPS_W-1:0]     max_q;
  logic [FPS_W-1:0]     jit_q;

  // Output register
  logic                 out_valid_q;
  stats_t               out_q;

  div_cmd_t             div_cmd;
  div_res_t             div_res;

  logic                 skip;
  logic [FPS_W-1:0]     quo_sat;
  logic [FPS_W-1:0]     jit_d;
  logic [JIT_W:0]       jit_add;
  logic [SUM_W:0]       sum_add;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic                 in_accept;
  logic                 out_load;

  function automatic logic [TIME_BITS-1:0] clamp_time(input logic [32:0] v);
    logic [TIME_BITS-1:0] r;
    if (v == '0) begin
      r = TIME_BITS'(1);
    end else if (v > TIME_MAX_W) begin
      r = '1;
    end else begin
      r = TIME_BITS'(v);
    end
    return r;
  endfunction

  assign in_accept = frame_i.valid && frame_i.ready;
  assign frame_i.ready = (state_q == ST_IDLE);

  // Load the output register once it is free or being taken
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || stats_o.ready);

  // Constant times the frame count: numerator of the average rate
  assign avg_prod = AVG_PROD_W'(ONE_SEC_Q8) * AVG_PROD_W'(frame_count_q);

  // Saturating accumulators
  assign sum_add = {1'b0, time_sum_q} + (SUM_W + 1)'(cur_t_q);
  assign jit_d   = (fi_q > div_res.quotient) ? (fi_q - div_res.quotient)
                                             : (div_res.quotient - fi_q);
  assign jit_add = {1'b0, jitter_sum_q} + (JIT_W + 1)'(jit_d);

  assign quo_sat = div_res.overflow ? '1 : div_res.quotient;

  // Operand select for the shared divider; an empty divisor skips the op
  always_comb begin
    div_cmd.dividend = RATE_DIVIDEND;
    div_cmd.divisor  = DIV_DEN_W'(ideal_t_q);
    div_cmd.steps    = RATE_STEPS;
    skip             = 1'b0;
    case (op_q)
      OP_FI: begin
        div_cmd.divisor = DIV_DEN_W'(ideal_t_q);
      end
      OP_FT: begin
        div_cmd.divisor = DIV_DEN_W'(cur_t_q);
      end
      OP_AVG: begin
        div_cmd.dividend = {avg_prod, {(DIV_NUM_W - AVG_PROD_W){1'b0}}};
        div_cmd.divisor  = DIV_DEN_W'(time_sum_q);
        div_cmd.steps    = WIDE_STEPS;
        skip             = (time_sum_q == '0);
      end
      OP_MIN: begin
        div_cmd.divisor = DIV_DEN_W'(longest_q);
        skip            = (longest_q == '0);
      end
      OP_MAX: begin
        div_cmd.divisor = DIV_DEN_W'(shortest_q);
        skip            = (frame_count_q == '0);
      end
      OP_JIT: begin
        div_cmd.dividend = {jitter_sum_q, {(DIV_NUM_W - JIT_W){1'b0}}};
        div_cmd.divisor  = DIV_DEN_W'(frame_count_q);
        div_cmd.steps    = WIDE_STEPS;
        skip             = (frame_count_q == '0);
      end
      default: begin
        skip = 1'b1;
      end
    endcase
    div_cmd.start = (state_q == ST_LAUNCH) && !skip;
  end

  frs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .res_o  (div_res)
  );

  // Sequencer: accept, update statistics, run the division list, publish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_FI;
      ideal_q       <= IDEAL_RESET;
      mode_q        <= MODE_RECORD;
      cur_t_q       <= '0;
      ideal_t_q     <= '0;
      started_q     <= 1'b0;
      frame_count_q <= '0;
      time_sum_q    <= '0;
      shortest_q    <= '1;
      longest_q     <= '0;
      jitter_sum_q  <= '0;
      fi_q          <= '0;
      avg_q         <= '0;
      min_q         <= '0;
      max_q         <= '0;
      jit_q         <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        ideal_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (stats_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            mode_q    <= frame_i.data.mode;
            ideal_t_q <= clamp_time(33'(ideal_q));
            // First frame after reset takes the ideal period
            cur_t_q   <= started_q ? clamp_time(33'(frame_i.data.elapsed_us))
                                   : clamp_time(33'(ideal_q));
            state_q   <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          if (mode_q == MODE_CLEAR) begin
            frame_count_q <= '0;
            time_sum_q    <= '0;
            shortest_q    <= '1;
            longest_q     <= '0;
            jitter_sum_q  <= '0;
            op_q          <= OP_AVG;
          end else begin
            started_q <= 1'b1;
            if (frame_count_q != '1) begin
              frame_count_q <= frame_count_q + COUNT_W'(1);
            end
            time_sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (cur_t_q < shortest_q) begin
              shortest_q <= cur_t_q;
            end
            if (cur_t_q > longest_q) begin
              longest_q <= cur_t_q;
            end
            op_q <= OP_FI;
          end
          state_q <= ST_LAUNCH;
        end

        ST_LAUNCH: begin
          if (skip) begin
            // Empty divisor: report zero and move on
            case (op_q)
              OP_AVG:  avg_q <= '0;
              OP_MIN:  min_q <= '0;
              OP_MAX:  max_q <= '0;
              OP_JIT:  jit_q <= '0;
              default: fi_q  <= fi_q;
            endcase
            if (op_q == OP_JIT) begin
              state_q <= ST_OUT;
            end else begin
              op_q <= op_e'(op_q + 3'd1);
            end
          end else begin
            state_q <= ST_WAIT;
          end
        end

        ST_WAIT: begin
          if (div_res.done) begin
            case (op_q)
              OP_FI: begin
                fi_q <= div_res.quotient;
              end
              OP_FT: begin
                // Accumulate |fps(ideal) - fps(t)|
                jitter_sum_q <= jit_add[JIT_W] ? '1 : jit_add[JIT_W-1:0];
              end
              OP_AVG:  avg_q <= quo_sat;
              OP_MIN:  min_q <= quo_sat;
              OP_MAX:  max_q <= quo_sat;
              OP_JIT:  jit_q <= quo_sat;
              default: fi_q  <= fi_q;
            endcase
            if (op_q == OP_JIT) begin
              state_q <= ST_OUT;
            end else begin
              op_q    <= op_e'(op_q + 3'd1);
              state_q <= ST_LAUNCH;
            end
          end
        end

        ST_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            out_q.average_fps <= avg_q;
            out_q.minimum_fps <= min_q;
            out_q.maximum_fps <= max_q;
            out_q.jitter_fps  <= jit_q;
            state_q           <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign stats_o.valid = out_valid_q;
  assign stats_o.data  = out_q;

  a_short_le_long : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_count_q != '0) |-> (shortest_q <= longest_q))
    else $error("shortest frame above longest frame");

  a_empty_stats : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_count_q == '0) |-> (time_sum_q == '0 && jitter_sum_q == '0))
    else $error("sums nonzero with no frames");

  a_start_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cmd.start |-> !div_res.busy)
    else $error("divider started while busy");

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_WAIT))
    else $error("divider result outside wait state");

endmodule
